/* hdl/mpss_pkg.sv */
// Shared types and constants for the Moffat star splatter unit.
// Used by mpss_ctrl, mpss_dpath and moffat_psf_star_splatter_unit; no dependencies.
package mpss_pkg;

    localparam int FRAME_W = 1024;
    localparam int FRAME_H = 1024;
    localparam int COL_W   = $clog2(FRAME_W);
    localparam int ROW_W   = $clog2(FRAME_H);
    localparam int ADDR_W  = COL_W + ROW_W;
    localparam int CRD_W   = 14;
    localparam int ACC_W   = 40;
    localparam int MARGIN  = 10;

    localparam logic [ACC_W-1:0] ACC_MAX = {ACC_W{1'b1}};
    localparam logic [31:0]      ONE_Q31 = 32'h8000_0000;

    localparam logic [1:0] OP_ADD   = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    localparam logic [1:0] CFG_RADIUS = 2'd0;
    localparam logic [1:0] CFG_SCALE  = 2'd1;
    localparam logic [1:0] CFG_BETA   = 2'd2;

    localparam logic [5:0]  RADIUS_RST = 6'd23;
    localparam logic [23:0] SCALE_RST  = 24'd114553;
    localparam logic [3:0]  BETA_RST   = 4'd5;

    typedef struct packed {
        logic capture;
        logic setup;
        logic sq;
        logic mlo;
        logic mhi;
        logic div_step;
        logic pow_step;
        logic lum;
        logic wr;
        logic rd_pix;
        logic clr_we;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic reject;
        logic empty;
        logic div_last;
        logic beta_zero;
        logic pow_last;
        logic last_px;
        logic clr_last;
    } t_stat;

endpackage

/* hdl/mpss_ctrl.sv */
// Sequencing state machine of the star splatter unit.
// Depends on mpss_pkg for the command and status structs and opcodes.
module mpss_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [1:0]           i_opcode,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output mpss_pkg::t_cmd       o_cmd,
    input  mpss_pkg::t_stat      i_stat
);

    localparam logic [3:0] S_RCLR  = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_SETUP = 4'd2;
    localparam logic [3:0] S_SQ    = 4'd3;
    localparam logic [3:0] S_MLO   = 4'd4;
    localparam logic [3:0] S_MHI   = 4'd5;
    localparam logic [3:0] S_DIV   = 4'd6;
    localparam logic [3:0] S_POW   = 4'd7;
    localparam logic [3:0] S_LUM   = 4'd8;
    localparam logic [3:0] S_WR    = 4'd9;
    localparam logic [3:0] S_READ  = 4'd10;
    localparam logic [3:0] S_OCLR  = 4'd11;
    localparam logic [3:0] S_DONE  = 4'd12;

    logic [3:0] r_state, n_state;
    logic       r_out_valid, n_out_valid;
    logic       w_accept;
    logic       w_out_free;

    assign w_accept   = i_in_valid && (r_state == S_IDLE);
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign o_in_stall = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_RCLR, S_OCLR: begin
                o_cmd.clr_we = 1'b1;
                if (i_stat.clr_last) begin
                    n_state = (r_state == S_RCLR) ? S_IDLE : S_DONE;
                end
            end
            S_IDLE: begin
                if (w_accept) begin
                    o_cmd.capture = 1'b1;
                    case (i_opcode)
                        mpss_pkg::OP_ADD:   n_state = S_SETUP;
                        mpss_pkg::OP_READ:  n_state = S_READ;
                        mpss_pkg::OP_CLEAR: n_state = S_OCLR;
                        default:            n_state = S_DONE;
                    endcase
                end
            end
            S_SETUP: begin
                o_cmd.setup = 1'b1;
                n_state = (i_stat.reject || i_stat.empty) ? S_DONE : S_SQ;
            end
            S_SQ: begin
                o_cmd.sq = 1'b1;
                n_state = S_MLO;
            end
            S_MLO: begin
                o_cmd.mlo = 1'b1;
                n_state = S_MHI;
            end
            S_MHI: begin
                o_cmd.mhi = 1'b1;
                n_state = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_stat.div_last) begin
                    n_state = i_stat.beta_zero ? S_LUM : S_POW;
                end
            end
            S_POW: begin
                o_cmd.pow_step = 1'b1;
                if (i_stat.pow_last) begin
                    n_state = S_LUM;
                end
            end
            S_LUM: begin
                o_cmd.lum = 1'b1;
                n_state = S_WR;
            end
            S_WR: begin
                o_cmd.wr = 1'b1;
                n_state = i_stat.last_px ? S_DONE : S_SQ;
            end
            S_READ: begin
                o_cmd.rd_pix = 1'b1;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (w_out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_RCLR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_out |-> (!r_out_valid || !i_out_stall))
        else $error("result loaded over an untaken result");

    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state != S_IDLE))
        else $error("accepted item did not start work");

    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(o_cmd) <= 1)
        else $error("more than one datapath command at once");

endmodule

/* hdl/mpss_dpath.sv */
// Datapath of the star splatter unit: configuration, window walk, weight
// arithmetic, divider and frame memory. Depends on mpss_pkg.
module mpss_dpath (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  mpss_pkg::t_cmd                 i_cmd,
    output mpss_pkg::t_stat                o_stat,
    input  logic                           i_cfg_we,
    input  logic [1:0]                     i_cfg_index,
    input  logic [23:0]                    i_cfg_data,
    input  logic [1:0]                     i_opcode,
    input  logic signed [20:0]             i_star_x,
    input  logic signed [20:0]             i_star_y,
    input  logic [31:0]                    i_star_luminosity,
    input  logic [9:0]                     i_read_col,
    input  logic [9:0]                     i_read_row,
    output logic                           o_accepted,
    output logic [mpss_pkg::ACC_W-1:0]     o_pixel_value
);

    localparam int CW = mpss_pkg::CRD_W;
    localparam int AW = mpss_pkg::ADDR_W;
    localparam int DW = mpss_pkg::ACC_W;
    localparam logic signed [CW-1:0] LO_LIM = -CW'(mpss_pkg::MARGIN);
    localparam logic signed [CW-1:0] XHI    = CW'(mpss_pkg::FRAME_W + mpss_pkg::MARGIN);
    localparam logic signed [CW-1:0] YHI    = CW'(mpss_pkg::FRAME_H + mpss_pkg::MARGIN);
    localparam logic signed [CW-1:0] XMAX   = CW'(mpss_pkg::FRAME_W);
    localparam logic signed [CW-1:0] YMAX   = CW'(mpss_pkg::FRAME_H);

    logic [5:0]  r_radius;
    logic [23:0] r_scale;
    logic [3:0]  r_beta;

    logic [1:0]         r_op;
    logic signed [20:0] r_sx, r_sy;
    logic [31:0]        r_lum;
    logic [9:0]         r_rcol, r_rrow;
    logic               r_acc;

    logic signed [CW-1:0] r_c0, r_c1, r_r1, r_col, r_row;
    logic [29:0] r_r2;
    logic [38:0] r_prod;
    logic [38:0] r_base;
    logic [38:0] r_rem;
    logic [31:0] r_q;
    logic [4:0]  r_cnt;
    logic [3:0]  r_pcnt;
    logic [31:0] r_p;
    logic [32:0] r_add;
    logic [DW-1:0] r_rdata;
    logic [AW-1:0] r_clr;

    logic [DW-1:0] mem [2**AW];

    // Floor of a Q.8 position is an arithmetic shift.
    logic signed [CW-1:0] w_cx, w_cy, w_c0, w_c1, w_r0, w_r1, w_rad;
    logic signed [CW-1:0] w_xm, w_xp, w_ym, w_yp;
    logic [22:0]        w_dxf, w_dyf;
    logic signed [15:0] w_dx, w_dy;
    logic signed [31:0] w_sqx, w_sqy;
    logic [38:0] w_hi;
    logic [53:0] w_tot;
    logic [39:0] w_rem2;
    logic [63:0] w_pp, w_lp;
    logic [DW:0] w_sum;
    logic [AW-1:0] w_pix_addr, w_rd_addr;
    logic        w_inframe;

    assign w_rad = CW'(r_radius);
    assign w_cx  = CW'(r_sx >>> 8);
    assign w_cy  = CW'(r_sy >>> 8);
    assign w_xm  = w_cx - w_rad;
    assign w_xp  = w_cx + w_rad;
    assign w_ym  = w_cy - w_rad;
    assign w_yp  = w_cy + w_rad;
    assign w_c0  = (w_xm < 0) ? '0 : w_xm;
    assign w_c1  = (w_xp > XMAX) ? XMAX : w_xp;
    assign w_r0  = (w_ym < 0) ? '0 : w_ym;
    assign w_r1  = (w_yp > YMAX) ? YMAX : w_yp;

    assign w_dxf = {{2{r_sx[20]}}, r_sx} - {r_col[CW-1], r_col, 8'b0};
    assign w_dyf = {{2{r_sy[20]}}, r_sy} - {r_row[CW-1], r_row, 8'b0};
    assign w_dx  = w_dxf[15:0];
    assign w_dy  = w_dyf[15:0];
    assign w_sqx = w_dx * w_dx;
    assign w_sqy = w_dy * w_dy;

    assign w_hi   = 39'(r_scale) * 39'(r_r2[29:15]);
    assign w_tot  = 54'(r_prod) + {w_hi[38:0], 15'b0};
    assign w_rem2 = {r_rem, 1'b0};
    assign w_pp   = 64'(r_p) * 64'(r_q);
    assign w_lp   = 64'(r_lum) * 64'(r_p);
    assign w_sum  = {1'b0, r_rdata} + (DW+1)'(r_add);

    assign w_pix_addr = {r_row[mpss_pkg::ROW_W-1:0], r_col[mpss_pkg::COL_W-1:0]};
    assign w_rd_addr  = {mpss_pkg::ROW_W'(r_rrow), mpss_pkg::COL_W'(r_rcol)};
    assign w_inframe  = (32'(r_rcol) < 32'(mpss_pkg::FRAME_W)) &&
                        (32'(r_rrow) < 32'(mpss_pkg::FRAME_H));

    assign o_stat.reject    = (w_cx < LO_LIM) || (w_cx > XHI) ||
                              (w_cy < LO_LIM) || (w_cy > YHI);
    assign o_stat.empty     = (w_c0 >= w_c1) || (w_r0 >= w_r1);
    assign o_stat.div_last  = (r_cnt == 5'd31);
    assign o_stat.beta_zero = (r_beta == 4'd0);
    assign o_stat.pow_last  = (r_pcnt == r_beta - 4'd1);
    assign o_stat.last_px   = (r_col + 1'b1 >= r_c1) && (r_row + 1'b1 >= r_r1);
    assign o_stat.clr_last  = (r_clr == {AW{1'b1}});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= mpss_pkg::RADIUS_RST;
            r_scale  <= mpss_pkg::SCALE_RST;
            r_beta   <= mpss_pkg::BETA_RST;
            r_clr    <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    mpss_pkg::CFG_RADIUS: r_radius <= i_cfg_data[5:0];
                    mpss_pkg::CFG_SCALE:  r_scale  <= i_cfg_data;
                    mpss_pkg::CFG_BETA:   r_beta   <= i_cfg_data[3:0];
                    default: ;
                endcase
            end
            if (i_cmd.clr_we) begin
                r_clr <= r_clr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op   <= i_opcode;
            r_sx   <= i_star_x;
            r_sy   <= i_star_y;
            r_lum  <= i_star_luminosity;
            r_rcol <= i_read_col;
            r_rrow <= i_read_row;
            r_acc  <= 1'b0;
        end
        if (i_cmd.setup) begin
            r_acc <= !o_stat.reject;
            r_c0  <= w_c0;
            r_c1  <= w_c1;
            r_r1  <= w_r1;
            r_col <= w_c0;
            r_row <= w_r0;
        end
        if (i_cmd.sq) begin
            r_r2 <= w_sqx[29:0] + w_sqy[29:0];
        end
        if (i_cmd.mlo) begin
            r_prod <= 39'(r_scale) * 39'(r_r2[14:0]);
        end
        if (i_cmd.mhi) begin
            r_base <= 39'(1 << 20) + 39'(w_tot >> 16);
            // The dividend 2^51 leaves 2^19 after its upper bits, all below base.
            r_rem  <= 39'(1 << 19);
            r_q    <= '0;
            r_cnt  <= '0;
            r_pcnt <= '0;
            r_p    <= mpss_pkg::ONE_Q31;
        end
        if (i_cmd.div_step) begin
            if (w_rem2 >= {1'b0, r_base}) begin
                r_rem <= 39'(w_rem2 - {1'b0, r_base});
                r_q   <= {r_q[30:0], 1'b1};
            end else begin
                r_rem <= w_rem2[38:0];
                r_q   <= {r_q[30:0], 1'b0};
            end
            r_cnt <= r_cnt + 1'b1;
        end
        if (i_cmd.pow_step) begin
            r_p    <= w_pp[62:31];
            r_pcnt <= r_pcnt + 1'b1;
        end
        if (i_cmd.lum) begin
            r_add <= w_lp[63:31];
        end
        if (i_cmd.wr) begin
            if (r_col + 1'b1 < r_c1) begin
                r_col <= r_col + 1'b1;
            end else begin
                r_col <= r_c0;
                r_row <= r_row + 1'b1;
            end
        end
        if (i_cmd.load_out) begin
            o_accepted    <= (r_op == mpss_pkg::OP_ADD) && r_acc;
            o_pixel_value <= ((r_op == mpss_pkg::OP_READ) && w_inframe) ? r_rdata : '0;
        end
    end

    // Frame memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_we) begin
            mem[r_clr] <= '0;
        end else if (i_cmd.wr) begin
            mem[w_pix_addr] <= w_sum[DW] ? mpss_pkg::ACC_MAX : w_sum[DW-1:0];
        end
        if (i_cmd.lum) begin
            r_rdata <= mem[w_pix_addr];
        end else if (i_cmd.rd_pix) begin
            r_rdata <= mem[w_rd_addr];
        end
    end

    a_rem_below_base: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_step |-> (r_rem < r_base))
        else $error("divider remainder not below divisor");

    a_weight_le_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.pow_step || i_cmd.lum) |-> (r_p <= mpss_pkg::ONE_Q31))
        else $error("weight above one");

endmodule

/* hdl/moffat_psf_star_splatter_unit.sv */
// Add star: walks a window of up to 46x46 pixels at radius 23; each pixel
// runs a 32-step bit-serial divider and beta serial multiplies.
// Clear frame: one memory word per cycle.
// One item at a time; a finished result waits in an output register.
// Reset (synchronous, active low) loads the register defaults and then clears the
// whole frame memory, during which no item is taken.
module moffat_psf_star_splatter_unit (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic [1:0]                 i_opcode,
    input  logic signed [20:0]         i_star_x,
    input  logic signed [20:0]         i_star_y,
    input  logic [31:0]                i_star_luminosity,
    input  logic [9:0]                 i_read_col,
    input  logic [9:0]                 i_read_row,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic                       o_accepted,
    output logic [39:0]                o_pixel_value,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [1:0]                 i_cfg_index,
    input  logic [23:0]                i_cfg_data
);

    mpss_pkg::t_cmd  w_cmd;
    mpss_pkg::t_stat w_stat;

    assign o_cfg_ready = 1'b1;

    mpss_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_opcode    (i_opcode),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (w_cmd),
        .i_stat      (w_stat)
    );

    mpss_dpath u_dpath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (w_cmd),
        .o_stat            (w_stat),
        .i_cfg_we          (i_cfg_valid && o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_opcode          (i_opcode),
        .i_star_x          (i_star_x),
        .i_star_y          (i_star_y),
        .i_star_luminosity (i_star_luminosity),
        .i_read_col        (i_read_col),
        .i_read_row        (i_read_row),
        .o_accepted        (o_accepted),
        .o_pixel_value     (o_pixel_value)
    );

endmodule
